[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the priority queue checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("priority queue check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("priority queue check failed");

`endif

[rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the sorted priority queue modules.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int unsigned DATA_W   = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned FILL_W   = 5;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		op_t                      func;
		logic signed [DATA_W-1:0] item_value;
		logic signed [DATA_W-1:0] item_priority;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] out_value;
		logic signed [DATA_W-1:0] out_priority;
		status_t                  status;
		logic [FILL_W-1:0]        fill_count;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;   // latch the accepted request
		logic exec;      // apply the latched request to the cells
	} spq_cmd_t;

endpackage

[rtl/spq_ifs.sv]
// ----------------------------------------------------------------------------
// spq_ifs
// Valid/ready channel interfaces for requests and responses.
// ----------------------------------------------------------------------------
interface spq_req_if
	import spq_pkg::*;
();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface spq_rsp_if
	import spq_pkg::*;
();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/sorted_priority_queue_core.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue_core: bounded max-first priority queue on sorted cells.
// A request is latched when accepted; the execute state then applies it to
// the cells and loads the response register, which raises the valid. New
// requests wait for the idle state; a stalled response holds off the next.
// Reset clears the controller and the entry count; entry cells are not reset.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core
	import spq_pkg::*;
#(
	parameter int unsigned CAPACITY = 16
) (
	input logic        clk,
	input logic        arst_n,
	spq_req_if.sink    req,
	spq_rsp_if.source  rsp
);

	// The controller owns both handshakes. A request is latched in the cycle
	// it is accepted and applied to the entry cells in the next cycle, which
	// also loads the response register. The response register frees the
	// request side: a new request is taken in the same cycle that the
	// previous response is taken downstream.
	spq_cmd_t cmd;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	// The datapath keeps the entries in descending priority order in a row
	// of cells. Every cell compares its priority against the new one in
	// parallel, so an insert or a remove completes in the execute state no
	// matter where the entry lands. A full queue drops the insert and an
	// empty queue rejects the remove, both reported in the status field.
	spq_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req_data (req.data),
		.rsp_data (rsp.data)
	);

endmodule

[rtl/spq_ctrl.sv]
// ----------------------------------------------------------------------------
// spq_ctrl
// Controller: handshakes on both channels and sequences capture and execute.
// ----------------------------------------------------------------------------
module spq_ctrl
	import spq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output spq_cmd_t cmd
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;

	// A new request may enter once the response register is empty or draining.
	assign req_ready   = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid   = rsp_valid_q;
	assign cmd.capture = req_valid && req_ready;
	assign cmd.exec    = (state_q == S_EXEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (rsp_valid_q && rsp_ready) begin
						rsp_valid_q <= 1'b0;
					end
					if (cmd.capture) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/spq_datapath.sv]
// ----------------------------------------------------------------------------
// spq_datapath
// Row of sorted entry cells, request latch, entry count and response register.
// ----------------------------------------------------------------------------
module spq_datapath
	import spq_pkg::*;
#(
	parameter int unsigned CAPACITY = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  spq_cmd_t cmd,
	input  req_t     req_data,
	output rsp_t     rsp_data
);

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	op_t                      op_s1;
	logic signed [DATA_W-1:0] val_s1;
	logic signed [DATA_W-1:0] pri_s1;

	logic signed [DATA_W-1:0] val_q [CAPACITY];
	logic signed [DATA_W-1:0] pri_q [CAPACITY];
	logic [CNT_W-1:0]         count_q;
	rsp_t                     rsp_q;

	logic [CAPACITY-1:0] keep_c;
	logic                full;
	logic                empty;
	logic                do_insert;
	logic                do_remove;
	logic [CNT_W-1:0]    count_next;
	logic [CNT_W+FILL_W-1:0] count_ext;
	status_t             status_next;

	assign full      = (count_q == CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);
	assign do_insert = (op_s1 == OP_INSERT) && !full;
	assign do_remove = (op_s1 == OP_REMOVE) && !empty;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_s1  <= req_data.func;
			val_s1 <= req_data.item_value;
			pri_s1 <= req_data.item_priority;
		end
	end

	// Each cell decides locally whether it keeps its entry. The flags form a
	// run of ones from the head, so the insert slot is the first cleared flag.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign keep_c[i] = !empty && !(pri_s1 > pri_q[i]);

			always_ff @(posedge clk) begin
				if (cmd.exec && do_insert && !keep_c[i]) begin
					val_q[i] <= val_s1;
					pri_q[i] <= pri_s1;
				end else if (cmd.exec && do_remove) begin
					val_q[i] <= val_q[i+1];
					pri_q[i] <= pri_q[i+1];
				end
			end
		end else begin : g_body
			assign keep_c[i] = (count_q > CNT_W'(i)) && (pri_q[i] > pri_s1);

			always_ff @(posedge clk) begin
				if (cmd.exec && do_insert && !keep_c[i]) begin
					if (keep_c[i-1]) begin
						val_q[i] <= val_s1;
						pri_q[i] <= pri_s1;
					end else begin
						val_q[i] <= val_q[i-1];
						pri_q[i] <= pri_q[i-1];
					end
				end else if (cmd.exec && do_remove && (i < CAPACITY - 1)) begin
					val_q[i] <= val_q[(i < CAPACITY - 1) ? i + 1 : i];
					pri_q[i] <= pri_q[(i < CAPACITY - 1) ? i + 1 : i];
				end
			end
		end
	end

	always_comb begin
		count_next  = count_q;
		status_next = ST_DONE;
		if (op_s1 == OP_INSERT) begin
			if (full) begin
				status_next = ST_FULL;
			end else begin
				count_next = count_q + CNT_W'(1);
			end
		end else begin
			if (empty) begin
				status_next = ST_EMPTY;
			end else begin
				count_next = count_q - CNT_W'(1);
			end
		end
	end

	assign count_ext = {{FILL_W{1'b0}}, count_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rsp_q.out_value    <= do_remove ? val_q[0] : '0;
			rsp_q.out_priority <= do_remove ? pri_q[0] : '0;
			rsp_q.status       <= status_next;
			rsp_q.fill_count   <= count_ext[FILL_W-1:0];
		end
	end

	assign rsp_data = rsp_q;

endmodule

[rtl/spq_checker.sv]
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spq_checker
	import spq_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_data
);

	// A stalled response keeps its valid and its contents.
	`SPQ_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

	// One request at a time: after an accept the queue drops its ready in the next cycle.
	`SPQ_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, req_valid && req_ready, !req_ready)

	// A rejected operation carries no entry.
	`SPQ_ASSERT_NOW(a_reject_zero, clk, arst_n, rsp_valid && (rsp_data.status != ST_DONE), (rsp_data.out_value == '0) && (rsp_data.out_priority == '0))

	// A remove on an empty queue leaves it empty.
	`SPQ_ASSERT_NOW(a_empty_count, clk, arst_n, rsp_valid && (rsp_data.status == ST_EMPTY), rsp_data.fill_count == '0)

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
